[rtl/vap_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// vap_pkg: shared types and constants of the vertex attribute packer
// Format codes, word structs and the lane conversion modes.
// ----------------------------------------------------------------------------
package vap_pkg;

  localparam int unsigned NumLanes = 4;

  typedef enum logic [3:0] {
    FMT_FLOAT1  = 4'd0,
    FMT_FLOAT2  = 4'd1,
    FMT_FLOAT3  = 4'd2,
    FMT_FLOAT4  = 4'd3,
    FMT_SHORT2  = 4'd4,
    FMT_SHORT2N = 4'd5,
    FMT_SHORT4  = 4'd6,
    FMT_SHORT4N = 4'd7,
    FMT_UBYTE4  = 4'd8,
    FMT_UBYTE4N = 4'd9,
    FMT_BYTE4   = 4'd10,
    FMT_BYTE4N  = 4'd11
  } format_e;

  // lane conversion mode
  typedef enum logic [2:0] {
    CONV_SHORT,
    CONV_SHORTN,
    CONV_UBYTE,
    CONV_UBYTEN,
    CONV_BYTE,
    CONV_BYTEN
  } conv_e;

  typedef struct packed {
    logic [3:0]  format;
    logic [2:0]  component_count;
    logic [31:0] comp_x;
    logic [31:0] comp_y;
    logic [31:0] comp_z;
    logic [31:0] comp_w;
  } in_word_t;

  typedef struct packed {
    logic [63:0] packed_low;
    logic [63:0] packed_high;
    logic [4:0]  byte_count;
    logic        format_error;
  } out_word_t;

  // decoded item control carried with the lane results
  typedef struct packed {
    logic        err;
    logic        is_float;
    logic [1:0]  elem_bytes_log; // 0: byte, 1: short
    logic [4:0]  byte_count;
    logic [127:0] raw;           // float words, already masked
  } ctrl_t;

endpackage
`default_nettype wire

[rtl/vertex_attribute_packer.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// vertex_attribute_packer: four-lane vertex attribute format converter
// Converts up to four float32 components into a packed 4..16 byte attribute.
// ----------------------------------------------------------------------------
//  channel | signals                     | direction
//  in      | in_valid_i, in_stall_o, in_word_i    | into block
//  out     | out_valid_o, out_stall_i, out_word_o | out of block
//
//  One word per cycle while the output is not stalled; each word passes the
//  decode+clamp register, then multiply, round and merge into the output
//  register. The pipeline advances whenever the output register is empty or
//  being taken; in_stall_o is high while a valid output word is stalled.
//  Reset clears only the valid bits.
module vertex_attribute_packer (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire vap_pkg::in_word_t  in_word_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output vap_pkg::out_word_t      out_word_o
);

  logic v1_q;
  logic adv;
  assign adv = !(out_valid_o && out_stall_i);
  assign in_stall_o = !adv;

  // decode
  vap_pkg::ctrl_t ctrl_d, c1_q, c2_q;
  vap_pkg::conv_e mode;
  logic [3:0]  fmt;
  logic [2:0]  cnt;
  logic [31:0] cw;
  always_comb begin
    fmt = in_word_i.format;
    cnt = in_word_i.component_count;
    cw  = in_word_i.comp_w;
    if (cnt == 3'd3 && fmt != vap_pkg::FMT_FLOAT3) begin
      cnt = 3'd4; cw = '0;
    end
    ctrl_d = '0;
    mode = vap_pkg::CONV_SHORT;
    ctrl_d.err = 1'b0;
    priority if (cnt == 3'd1 && fmt == vap_pkg::FMT_FLOAT1) begin
      ctrl_d.is_float = 1'b1; ctrl_d.byte_count = 5'd4;
      ctrl_d.raw = {96'd0, in_word_i.comp_x};
    end else if (cnt == 3'd2 && fmt == vap_pkg::FMT_FLOAT2) begin
      ctrl_d.is_float = 1'b1; ctrl_d.byte_count = 5'd8;
      ctrl_d.raw = {64'd0, in_word_i.comp_y, in_word_i.comp_x};
    end else if (cnt == 3'd2 && (fmt == vap_pkg::FMT_SHORT2 ||
                                 fmt == vap_pkg::FMT_SHORT2N)) begin
      ctrl_d.elem_bytes_log = 2'd1; ctrl_d.byte_count = 5'd4;
      mode = (fmt == vap_pkg::FMT_SHORT2) ? vap_pkg::CONV_SHORT : vap_pkg::CONV_SHORTN;
    end else if (cnt == 3'd3 && fmt == vap_pkg::FMT_FLOAT3) begin
      ctrl_d.is_float = 1'b1; ctrl_d.byte_count = 5'd12;
      ctrl_d.raw = {32'd0, in_word_i.comp_z, in_word_i.comp_y, in_word_i.comp_x};
    end else if (cnt == 3'd4 && fmt == vap_pkg::FMT_FLOAT4) begin
      ctrl_d.is_float = 1'b1; ctrl_d.byte_count = 5'd16;
      ctrl_d.raw = {cw, in_word_i.comp_z, in_word_i.comp_y, in_word_i.comp_x};
    end else if (cnt == 3'd4 && (fmt == vap_pkg::FMT_SHORT4 ||
                                 fmt == vap_pkg::FMT_SHORT4N)) begin
      ctrl_d.elem_bytes_log = 2'd1; ctrl_d.byte_count = 5'd8;
      mode = (fmt == vap_pkg::FMT_SHORT4) ? vap_pkg::CONV_SHORT : vap_pkg::CONV_SHORTN;
    end else if (cnt == 3'd4 && fmt >= vap_pkg::FMT_UBYTE4 &&
                 fmt <= vap_pkg::FMT_BYTE4N) begin
      ctrl_d.byte_count = 5'd4;
      unique case (fmt)
        vap_pkg::FMT_UBYTE4:  mode = vap_pkg::CONV_UBYTE;
        vap_pkg::FMT_UBYTE4N: mode = vap_pkg::CONV_UBYTEN;
        vap_pkg::FMT_BYTE4:   mode = vap_pkg::CONV_BYTE;
        default:              mode = vap_pkg::CONV_BYTEN;
      endcase
    end else begin
      ctrl_d.err = 1'b1;
    end
  end

  logic [31:0] lane_in [vap_pkg::NumLanes];
  logic [63:0] elems;
  assign lane_in[0] = in_word_i.comp_x;
  assign lane_in[1] = in_word_i.comp_y;
  assign lane_in[2] = in_word_i.comp_z;
  assign lane_in[3] = cw;

  for (genvar g = 0; g < vap_pkg::NumLanes; g++) begin : g_lane
    vap_lane u_lane (
      .clk_i  (clk_i),
      .en_i   (adv),
      .comp_i (lane_in[g]),
      .mode_i (mode),
      .elem_o (elems[16*g +: 16])
    );
  end

  vap_pkg::out_word_t merged;
  vap_merge u_merge (
    .ctrl_i  (c2_q),
    .elems_i (elems),
    .word_o  (merged)
  );

  // lane stage 2 is combinational after its stage 1 register; c2 aligns
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      out_valid_o <= 1'b0;
    end else if (adv) begin
      v1_q <= in_valid_i;
      out_valid_o <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      c1_q <= ctrl_d;
      out_word_o <= merged;
    end
  end

  assign c2_q = c1_q;

endmodule
`default_nettype wire

[rtl/vap_lane.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// vap_lane: two-stage component converter; int modes clamp and truncate
// Norm modes: clamp, scale in float32 with RNE, round half away from zero.
// ----------------------------------------------------------------------------
module vap_lane (
  input  wire logic            clk_i,
  input  wire logic            en_i,
  input  wire logic [31:0]     comp_i,
  input  wire vap_pkg::conv_e  mode_i,
  output logic [15:0]          elem_o
);

  logic        sgn;
  logic [7:0]  ex;
  logic [22:0] man;
  logic        is_nan;
  logic [23:0] sig;

  assign sgn    = comp_i[31];
  assign ex     = comp_i[30:23];
  assign man    = comp_i[22:0];
  assign is_nan = (ex == 8'hFF) && (man != 23'd0);
  assign sig    = {(ex != 8'd0), man};

  // integer part of |v| truncated, for |v| < 2^15 (ex <= 141)
  logic [15:0] int_mag;
  logic        big;
  always_comb begin
    logic [7:0] sh;
    sh = 8'd150 - ex;
    big = (ex >= 8'd142);
    if (ex < 8'd127) int_mag = 16'd0;
    else if (big) int_mag = 16'hFFFF;
    else int_mag = 16'(sig >> sh[4:0]);
  end

  // stage 1: integer result or clamped significand for the scaled path
  logic [15:0]    int_d, int_q;
  logic           norm_d, norm_q;
  logic [23:0]    nsig_d, nsig_q;   // |v| significand, |v| <= 1
  logic [7:0]     nex_d, nex_q;
  logic           nneg_d, nneg_q;
  vap_pkg::conv_e mode_q;

  always_comb begin
    int_d  = '0;
    norm_d = 1'b0;
    nsig_d = sig;
    nex_d  = ex;
    nneg_d = sgn;
    unique case (mode_i)
      vap_pkg::CONV_SHORT: begin
        if (is_nan) int_d = '0;
        else if (sgn) int_d = (big) ? 16'h8000 : 16'(-int_mag);
        else int_d = (ex >= 8'd142) ? 16'h7FFF : int_mag;
      end
      vap_pkg::CONV_UBYTE: begin
        if (is_nan || sgn) int_d = '0;
        else int_d = (ex >= 8'd135) ? 16'd255 : int_mag;
      end
      vap_pkg::CONV_BYTE: begin
        if (is_nan) int_d = '0;
        else if (sgn) int_d = (ex >= 8'd134) ? 16'hFF80 : 16'(-int_mag);
        else int_d = (ex >= 8'd134) ? 16'd127 : int_mag;
      end
      default: begin
        norm_d = 1'b1;
        if (is_nan || (sgn && mode_i == vap_pkg::CONV_UBYTEN)) begin
          nsig_d = '0; nex_d = '0;
        end else if (ex >= 8'd127) begin
          nsig_d = 24'h800000; nex_d = 8'd127;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      int_q  <= int_d;
      norm_q <= norm_d;
      nsig_q <= nsig_d;
      nex_q  <= nex_d;
      nneg_q <= nneg_d && (nsig_d != 24'd0);
      mode_q <= mode_i;
    end
  end

  // stage 2: product |v|*K exact, then RNE to 24 bits, then round half away
  logic [15:0] kval;
  always_comb begin
    unique case (mode_q)
      vap_pkg::CONV_SHORTN: kval = 16'd32767;
      vap_pkg::CONV_UBYTEN: kval = 16'd255;
      default:              kval = 16'd127;
    endcase
  end

  logic [39:0] prod;      // sig * K, value = prod * 2^(nex-150)
  logic [15:0] rmag;
  always_comb begin
    logic [5:0]  msb;
    logic [5:0]  lsbpos;  // position of float32 ulp in prod
    logic [39:0] mask, rem, half, rp;
    logic [7:0]  sh;
    logic [39:0] iv;
    logic [55:0] fx;      // rounded product, scaled 2^16 fixed point
    prod = 40'(nsig_q) * 40'(kval);
    msb = 6'd0;
    for (int b = 0; b < 40; b++) if (prod[b]) msb = 6'(b);
    lsbpos = (msb > 6'd23) ? msb - 6'd23 : 6'd0;
    mask = (40'd1 << lsbpos) - 40'd1;
    rem  = prod & mask;
    half = (lsbpos == 6'd0) ? 40'd0 : (40'd1 << (lsbpos - 6'd1));
    rp   = prod & ~mask;
    if (lsbpos != 6'd0 && (rem > half || (rem == half && prod[lsbpos])))
      rp = rp + (40'd1 << lsbpos);
    // value = rp * 2^(nex-150); take 16 fraction bits
    sh = 8'd150 - nex_q;  // >= 23 since nex <= 127
    if (nsig_q == 24'd0 || sh > 8'd80) fx = '0;
    else if (sh >= 8'd16) fx = 56'({rp, 16'd0} >> sh);
    else fx = 56'({rp, 16'd0} >> sh);
    iv = 40'(fx >> 16);
    rmag = 16'(iv) + 16'(fx[15]);
  end

  always_comb begin
    if (!norm_q) elem_o = int_q;
    else elem_o = nneg_q ? 16'(-rmag) : rmag;
  end

endmodule
`default_nettype wire

[rtl/vap_merge.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// vap_merge: packs lane elements into the output word
// Places shorts or bytes little-endian, passes float words through, or zeroes the word on error.
// ----------------------------------------------------------------------------
module vap_merge (
  input  wire vap_pkg::ctrl_t     ctrl_i,
  input  wire logic [63:0]        elems_i,
  output vap_pkg::out_word_t      word_o
);

  logic [127:0] buf_v;
  always_comb begin
    buf_v = '0;
    if (ctrl_i.err) buf_v = '0;
    else if (ctrl_i.is_float) buf_v = ctrl_i.raw;
    else if (ctrl_i.elem_bytes_log == 2'd1) begin
      for (int i = 0; i < 4; i++) buf_v[16*i +: 16] = elems_i[16*i +: 16];
      if (ctrl_i.byte_count == 5'd4) buf_v[127:32] = '0;
    end else begin
      for (int i = 0; i < 4; i++) buf_v[8*i +: 8] = elems_i[16*i +: 8];
    end
    word_o.packed_low   = buf_v[63:0];
    word_o.packed_high  = buf_v[127:64];
    word_o.byte_count   = ctrl_i.byte_count;
    word_o.format_error = ctrl_i.err;
  end

endmodule
`default_nettype wire
